### src/lfsa_pkg.sv
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants for the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  // Default sizing
  localparam int unsigned SlotCountDef  = 64;
  localparam int unsigned OwnerCountDef = 1024;

  // Fixed payload widths
  localparam int unsigned OwnerW  = 10;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    FN_ACQUIRE = 1'b0,
    FN_RELEASE = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_UNSEATED = 2'd2,
    ST_SEATED   = 2'd3
  } status_e;

endpackage

### src/lfsa_req_if.sv
// ----------------------------------------------------------------------------
// lfsa_req_if
// Request channel: acquire/release by an owner ID, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfsa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lfsa_pkg::OwnerW-1:0]   owner;

  modport source (output valid, func, owner, input ready);
  modport sink   (input valid, func, owner, output ready);
endinterface

### src/lfsa_rsp_if.sv
// ----------------------------------------------------------------------------
// lfsa_rsp_if
// Response channel: slot, status and watched-owner flag, valid/ready.
// ----------------------------------------------------------------------------
interface lfsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lfsa_pkg::SlotW-1:0]     slot;
  logic [lfsa_pkg::StatusW-1:0]   status;
  logic                           watched_hit;

  modport source (output valid, slot, status, watched_hit, input ready);
  modport sink   (input valid, slot, status, watched_hit, output ready);
endinterface

### src/lfsa_prio_enc.sv
// ----------------------------------------------------------------------------
// lfsa_prio_enc
// Lowest-set-bit priority encoder over the free-slot bitmap.
// ----------------------------------------------------------------------------
module lfsa_prio_enc #(
  parameter int unsigned WIDTH = lfsa_pkg::SlotCountDef
) (
  input  logic [WIDTH-1:0]         bits_i,
  output logic                     found_o,
  output logic [$clog2(WIDTH)-1:0] idx_o
);

  localparam int unsigned IdxW = $clog2(WIDTH);

  // scan from the top so the lowest set bit wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (bits_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

### src/lowest_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Grants the lowest free slot to an acquiring owner and frees it on release.
// ----------------------------------------------------------------------------
// Path: the owner table is read into a register at request accept, then
//   execute fills the response register once that register is free or taken.
// Throughput: one transaction per cycle unless the response stalls; the owner
//   table has one write and one read port, the previous write forwarded to execute.
// Reset: all slots free, watched owner 0; then a clearing pass zeroes every
//   owner table entry while requests are held off.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator #(
  parameter int unsigned SLOT_COUNT  = lfsa_pkg::SlotCountDef,
  parameter int unsigned OWNER_COUNT = lfsa_pkg::OwnerCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // watched owner register
  input  logic                        cfg_we_i,
  input  logic [lfsa_pkg::OwnerW-1:0] cfg_wdata_i,
  // channels
  lfsa_req_if.sink                    req_i,
  lfsa_rsp_if.source                  rsp_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);   // slot index width
  localparam int unsigned AW = $clog2(OWNER_COUNT);  // owner table address width

  // owner table entry: seated flag plus the slot held
  typedef struct packed {
    logic          seated;
    logic [SW-1:0] slot;
  } entry_t;

  // clear pass / run
  typedef enum logic [1:0] {
    S_CLEAR = 2'b01,
    S_RUN   = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  // watched owner register
  logic [lfsa_pkg::OwnerW-1:0] watched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q <= '0;
    end else if (cfg_we_i) begin
      watched_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass: one table entry per cycle after reset
  // --------------------------------------------------------------------------
  logic clr_last;
  assign clr_last = (clr_addr_q == AW'(OWNER_COUNT - 1));

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_last) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: accept a request and launch the owner table read
  // --------------------------------------------------------------------------
  logic          ex_valid_q;
  logic          ex_fire;
  logic          req_fire;
  logic [AW-1:0] req_addr;

  assign req_i.ready = (state_q == S_RUN) && (!ex_valid_q || ex_fire);
  assign req_fire    = req_i.valid && req_i.ready;
  assign req_addr    = AW'(req_i.owner);

  logic                        ex_func_q;
  logic [lfsa_pkg::OwnerW-1:0] ex_owner_q;
  logic                        ex_in_range_q;
  logic [AW-1:0]               ex_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (req_fire) begin
      ex_valid_q <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      ex_func_q     <= req_i.func;
      ex_owner_q    <= req_i.owner;
      // owners past the table size are never seated
      ex_in_range_q <= (32'(req_i.owner) < 32'(OWNER_COUNT));
      ex_addr_q     <= req_addr;
    end
  end

  // --------------------------------------------------------------------------
  // Owner table: one write port, one registered read port
  // --------------------------------------------------------------------------
  entry_t mem [OWNER_COUNT];
  entry_t rdata_q;
  logic   mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t mem_wdata;

  logic   wr_en;
  entry_t wr_entry;

  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = ex_fire && wr_en;
      mem_waddr = ex_addr_q;
      mem_wdata = wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rdata_q <= mem[req_addr];
    end
  end

  // Forward the last execute write: the read of the next request is taken
  // at the same edge and sees the old entry.
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  entry_t        fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (ex_fire && wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire && wr_en) begin
      fwd_addr_q <= ex_addr_q;
      fwd_data_q <= wr_entry;
    end
  end

  entry_t ent;
  assign ent = (fwd_valid_q && (fwd_addr_q == ex_addr_q)) ? fwd_data_q : rdata_q;

  // --------------------------------------------------------------------------
  // Stage 2: execute against the bitmap, write back, fill the response
  // --------------------------------------------------------------------------
  logic [SLOT_COUNT-1:0] free_map_q;
  logic                  pe_found;
  logic [SW-1:0]         pe_idx;

  lfsa_prio_enc #(
    .WIDTH (SLOT_COUNT)
  ) u_prio_enc (
    .bits_i  (free_map_q),
    .found_o (pe_found),
    .idx_o   (pe_idx)
  );

  logic              seat_ok;     // successful acquire
  logic              free_ok;     // successful release
  logic [SW-1:0]     res_slot;
  lfsa_pkg::status_e res_status;
  logic              res_hit;

  always_comb begin
    seat_ok    = 1'b0;
    free_ok    = 1'b0;
    res_slot   = '0;
    res_status = lfsa_pkg::ST_OK;
    res_hit    = 1'b0;
    priority if (!ex_in_range_q) begin
      res_status = lfsa_pkg::ST_UNSEATED;
    end else if (ex_func_q == lfsa_pkg::FN_ACQUIRE) begin
      if (ent.seated) begin
        res_status = lfsa_pkg::ST_SEATED;
      end else if (!pe_found) begin
        res_status = lfsa_pkg::ST_FULL;
      end else begin
        seat_ok  = 1'b1;
        res_slot = pe_idx;
        res_hit  = (ex_owner_q == watched_q);
      end
    end else begin
      if (!ent.seated) begin
        res_status = lfsa_pkg::ST_UNSEATED;
      end else begin
        free_ok  = 1'b1;
        res_slot = ent.slot;
      end
    end
  end

  assign wr_en           = seat_ok || free_ok;
  assign wr_entry.seated = seat_ok;
  assign wr_entry.slot   = res_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q <= '1;
    end else if (ex_fire && seat_ok) begin
      free_map_q[pe_idx] <= 1'b0;
    end else if (ex_fire && free_ok) begin
      free_map_q[ent.slot] <= 1'b1;
    end
  end

  // Response register
  logic                         out_valid_q;
  logic [lfsa_pkg::SlotW-1:0]   out_slot_q;
  lfsa_pkg::status_e            out_status_q;
  logic                         out_hit_q;

  assign ex_fire = ex_valid_q && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ex_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_slot_q   <= lfsa_pkg::SlotW'(res_slot);  // low bits of wide slot numbers
      out_status_q <= res_status;
      out_hit_q    <= res_hit;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.slot        = out_slot_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.watched_hit = out_hit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // no request reaches execute while the table is being cleared
  a_no_exec_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !ex_valid_q)
    else $error("execute active during clearing pass");

  // a granted slot is marked taken afterwards
  a_grant_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && seat_ok) |=> !free_map_q[$past(pe_idx)])
    else $error("granted slot still marked free");

  // a release only frees a slot that was taken
  a_release_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && free_ok) |-> !free_map_q[ent.slot])
    else $error("release of a slot already free");

  // an error response carries slot zero and no watched flag
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != lfsa_pkg::ST_OK)) |-> (out_slot_q == '0) && !out_hit_q)
    else $error("error response with slot or watched flag set");

endmodule
